FILE: hw/rtl/kctt_pkg.sv
`timescale 1ns / 1ps

package kctt_pkg;

  // Table size and timer width.
  localparam int KEY_COUNT = 256;
  localparam int TIME_BITS = 16;
  localparam int KEY_BITS  = $clog2(KEY_COUNT);

  // Fixed field widths of the item and result beats.
  localparam int KIND_W  = 2;
  localparam int KEY_W   = 8;
  localparam int FTIME_W = 16;
  localparam int COUNT_W = 9;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [KEY_BITS-1:0]  idx_t;
  typedef logic [COUNT_W-1:0]   count_t;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

  // Result status codes.
  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_DRAIN,
    ST_POST
  } kctt_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic apply;
    logic sweep_init;
    logic sweep_read;
    logic out_load;
  } kctt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic sweep_last;
    logic out_free;
  } kctt_stat_t;

endpackage

FILE: hw/rtl/kctt_if.sv
`timescale 1ns / 1ps

// Item channel: one beat carries one add, remove or tick request.
interface kctt_item_if import kctt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [KEY_W-1:0]   key;
  logic [FTIME_W-1:0] delay;
  logic [FTIME_W-1:0] elapsed;

  modport source (output valid, kind, key, delay, elapsed, input ready);
  modport sink (input valid, kind, key, delay, elapsed, output ready);
endinterface

// Result channel: one beat per item.
interface kctt_result_if import kctt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               status;
  logic [COUNT_W-1:0] armed_count;

  modport source (output valid, status, armed_count, input ready);
  modport sink (input valid, status, armed_count, output ready);
endinterface

FILE: hw/rtl/kctt_dpath.sv
`timescale 1ns / 1ps

module kctt_dpath import kctt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kctt_cmd_t          cmd_i,
  output kctt_stat_t         stat_o,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [KEY_W-1:0]   key_i,
  input  logic [FTIME_W-1:0] delay_i,
  input  logic [FTIME_W-1:0] elapsed_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic               out_status_o,
  output logic [COUNT_W-1:0] out_count_o
);

  // Captured item.
  logic [KIND_W-1:0] kind_q;
  logic [KEY_W-1:0]  key_q;
  time_t             delay_q;
  time_t             elapsed_q;

  // Table state.
  logic [KEY_COUNT-1:0] valid_q, valid_d;
  count_t               count_q, count_d;
  time_t                mem_q [KEY_COUNT];
  time_t                rdata_q;

  // Sweep pipeline.
  idx_t sweep_idx_q;
  idx_t wb_idx_q;
  logic wb_pend_q;

  // Result.
  logic   status_q, status_d;
  logic   out_valid_q;
  logic   out_status_q;
  count_t out_count_q;

  // Memory write port.
  logic  mem_we;
  idx_t  mem_waddr;
  time_t mem_wdata;

  idx_t key_idx;
  logic key_in_range;

  assign key_idx      = key_q[KEY_BITS-1:0];
  assign key_in_range = ({1'b0, key_q} < COUNT_W'(KEY_COUNT));

  // Capture the accepted item; times are taken in their low timer bits.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q    <= kind_i;
      key_q     <= key_i;
      delay_q   <= TIME_BITS'(delay_i);
      elapsed_q <= TIME_BITS'(elapsed_i);
    end
  end

  // Add and remove act in one step; the sweep writes back one entry a cycle.
  always_comb begin
    valid_d   = valid_q;
    count_d   = count_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_waddr = key_idx;
    mem_wdata = delay_q;
    if (cmd_i.apply) begin
      status_d = STATUS_DONE;
      if (kind_q == KIND_ADD && key_in_range) begin
        if (valid_q[key_idx]) begin
          status_d = STATUS_REFUSED;
        end else begin
          valid_d[key_idx] = 1'b1;
          count_d          = count_q + 1'b1;
          mem_we           = 1'b1;
        end
      end else if (kind_q == KIND_REMOVE && key_in_range && valid_q[key_idx]) begin
        valid_d[key_idx] = 1'b0;
        count_d          = count_q - 1'b1;
      end
    end
    if (cmd_i.sweep_init) begin
      status_d = STATUS_DONE;
    end
    if (wb_pend_q && valid_q[wb_idx_q]) begin
      if (rdata_q <= elapsed_q) begin
        valid_d[wb_idx_q] = 1'b0;
        count_d           = count_q - 1'b1;
      end else begin
        mem_we    = 1'b1;
        mem_waddr = wb_idx_q;
        mem_wdata = rdata_q - elapsed_q;
      end
    end
  end

  // Valid marks, armed count, sweep control and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      count_q     <= '0;
      status_q    <= STATUS_DONE;
      wb_pend_q   <= 1'b0;
      sweep_idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q   <= valid_d;
      count_q   <= count_d;
      status_q  <= status_d;
      wb_pend_q <= cmd_i.sweep_read;
      if (cmd_i.sweep_init) begin
        sweep_idx_q <= '0;
      end else if (cmd_i.sweep_read) begin
        sweep_idx_q <= sweep_idx_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Timer memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.sweep_read) begin
      rdata_q <= mem_q[sweep_idx_q];
    end
    wb_idx_q <= sweep_idx_q;
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_count_q  <= count_q;
    end
  end

  assign stat_o.is_tick    = (kind_q == KIND_TICK);
  assign stat_o.sweep_last = (sweep_idx_q == KEY_BITS'(KEY_COUNT - 1));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_count_o  = out_count_q;

endmodule

FILE: hw/rtl/kctt_ctrl.sv
`timescale 1ns / 1ps

module kctt_ctrl import kctt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  kctt_stat_t stat_i,
  output kctt_cmd_t  cmd_o
);

  kctt_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = stat_i.is_tick ? ST_SWEEP : ST_POST;
      end
      ST_SWEEP: begin
        if (stat_i.sweep_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_POST;
      end
      ST_POST: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.sweep_init = stat_i.is_tick;
        cmd_o.apply      = !stat_i.is_tick;
      end
      ST_SWEEP: begin
        cmd_o.sweep_read = 1'b1;
      end
      ST_DRAIN: begin
        cmd_o = '0;
      end
      ST_POST: begin
        cmd_o.out_load = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/keyed_cooldown_timer_table_unit.sv
`timescale 1ns / 1ps

// Keeps one countdown timer per key code and answers every item with one
// result beat carrying a status and the number of armed keys. For an add or a
// remove, the item is captured in ST_IDLE, applied in ST_EXEC and its result
// loaded into the output register from ST_POST; the unit then returns to
// ST_IDLE for the next item beat. For a tick, ST_EXEC starts a sweep over all
// KEY_COUNT timers in ST_SWEEP, followed by ST_DRAIN and ST_POST. The sweep
// reads one timer a cycle from the timer memory and, on the next cycle, while
// the following timer is read, writes an armed timer's new remainder back or,
// if that timer has run out, clears its armed mark. One item is worked on at a
// time. The next item beat is taken as soon as the previous result sits in the
// output register, even if that result has not been taken yet. If a new result
// finds the output register still full, it waits until the held beat is taken,
// and the input stays closed for that time. Timer contents are not cleared at
// reset; only the per-key armed marks and the armed count are.
module keyed_cooldown_timer_table_unit import kctt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  kctt_item_if.sink   item_i,
  kctt_result_if.source result_o
);

  kctt_cmd_t  cmd;
  kctt_stat_t stat;

  // Sequencer.
  kctt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Timer table and result register.
  kctt_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .kind_i       (item_i.kind),
    .key_i        (item_i.key),
    .delay_i      (item_i.delay),
    .elapsed_i    (item_i.elapsed),
    .out_ready_i  (result_o.ready),
    .out_valid_o  (result_o.valid),
    .out_status_o (result_o.status),
    .out_count_o  (result_o.armed_count)
  );

endmodule
